FILE: src/simple_moving_average_macros.svh
// Assertion helpers shared by the block's modules.
// Each expects clk and arst_n in scope.
`ifndef SIMPLE_MOVING_AVERAGE_MACROS_SVH
`define SIMPLE_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication.
`define SMA_ASSERT_NOW(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("moving average check failed");

// Next-cycle implication.
`define SMA_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("moving average check failed");

`endif

FILE: src/sma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sma_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = 20;
	localparam int WS_W       = 5;
	localparam int AVG_W      = 20;
	// numerator is sum*20 + n, divisor is 2n with n at most 31
	localparam int NUM_W      = 25;
	localparam int DEN_W      = 6;
	localparam int DIV_STEPS  = NUM_W;
	localparam int DIV_CNT_W  = 5;

	localparam int            WINDOW_MAX_DEF    = 16;
	localparam logic [WS_W-1:0] WINDOW_SIZE_RST = 5'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_LOAD,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

FILE: src/sma_window.sv
`timescale 1ns / 1ps
`default_nettype none

module sma_window #(
	parameter int DEPTH  = sma_pkg::WINDOW_MAX_DEF,
	parameter int ADDR_W = 4
) (
	input  wire                           clk,
	input  wire                           rd_en,
	input  wire  [ADDR_W-1:0]             rd_addr,
	output logic [sma_pkg::SAMPLE_W-1:0]  rd_data,
	input  wire                           wr_en,
	input  wire  [ADDR_W-1:0]             wr_addr,
	input  wire  [sma_pkg::SAMPLE_W-1:0]  wr_data
);

	logic [sma_pkg::SAMPLE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: src/sma_divider.sv
`timescale 1ns / 1ps
`default_nettype none

`include "simple_moving_average_macros.svh"

// Restoring divider, one quotient bit per cycle.
module sma_divider (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire sma_pkg::div_req_t       req,
	output sma_pkg::div_stat_t           stat,
	output logic [sma_pkg::NUM_W-1:0]    quotient
);

	localparam logic [sma_pkg::DIV_CNT_W-1:0] CNT_LAST =
		sma_pkg::DIV_CNT_W'(sma_pkg::DIV_STEPS - 1);

	logic                          busy_q;
	logic [sma_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [sma_pkg::NUM_W-1:0]     num_q;
	logic [sma_pkg::DEN_W-1:0]     rem_q;
	logic [sma_pkg::DEN_W-1:0]     den_q;
	logic [sma_pkg::DEN_W:0]       trial;
	logic                          qbit;
	logic [sma_pkg::DEN_W:0]       diff;

	// remainder stays below the divisor, so the shifted trial fits one extra bit
	always_comb begin
		trial = {rem_q, num_q[sma_pkg::NUM_W-1]};
		qbit  = (trial >= {1'b0, den_q});
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_LAST;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[sma_pkg::NUM_W-2:0], qbit};
			rem_q <= qbit ? diff[sma_pkg::DEN_W-1:0] : trial[sma_pkg::DEN_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == '0);
	assign quotient  = num_q;

	`SMA_ASSERT_NEXT(a_start_runs, req.start, busy_q && cnt_q == CNT_LAST)
	`SMA_ASSERT_NOW(a_no_restart, busy_q, !req.start)

endmodule

`default_nettype wire

FILE: src/simple_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none

`include "simple_moving_average_macros.svh"

// Moving average of unsigned 16-bit samples over a window of window_size samples (1..31,
// capped at WINDOW_MAX). Once a list has delivered a full window, each sample yields
// the window mean times ten, rounded half up: floor((20*sum + n) / (2n)). A sample
// flagged end_of_list clears the history after it is processed, as does a write of
// window_size; shorter lists give no output. An item that yields a result passes
// through UPDATE, LOAD, DIVIDE and EMIT, spending most of that in the 25 one-bit steps of
// the serial divider, and the next item is accepted once the block is back in IDLE. An
// item without a result goes through UPDATE only; with a window size of zero it is
// taken in IDLE. in_stall stays high until the item is finished, longer while an
// earlier result is still stalled at the output.
module simple_moving_average #(
	parameter int WINDOW_MAX = sma_pkg::WINDOW_MAX_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_wr_en,
	input  wire  [sma_pkg::WS_W-1:0]       cfg_wr_data,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [sma_pkg::SAMPLE_W-1:0]   sample_value,
	input  wire                            end_of_list,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [sma_pkg::AVG_W-1:0]      average_tenths
);

	localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CMP_W = (PTR_W + 1 > 6) ? PTR_W + 1 : 6;

	sma_pkg::state_t state_q, state_d;

	logic [sma_pkg::WS_W-1:0]     window_size_q;
	logic [sma_pkg::SUM_W-1:0]    sum_q;
	logic [sma_pkg::WS_W-1:0]     fill_q;
	logic [PTR_W-1:0]             wp_q;
	logic [PTR_W-1:0]             slot_q;
	logic [sma_pkg::SAMPLE_W-1:0] sample_q;
	logic                         last_q;
	logic                         out_valid_q;
	logic [sma_pkg::AVG_W-1:0]    avg_q;

	logic [sma_pkg::WS_W-1:0]     n_w;
	logic [PTR_W-1:0]             slot_w;
	logic [CMP_W-1:0]             slot_inc;
	logic                         accept;
	logic                         full_w;
	logic                         emit_go;
	logic [sma_pkg::SAMPLE_W-1:0] old_sample;

	sma_pkg::div_req_t  div_req;
	sma_pkg::div_stat_t div_stat;
	logic [sma_pkg::NUM_W-1:0] quotient;

	always_comb begin
		if (32'(window_size_q) > WINDOW_MAX) begin
			n_w = sma_pkg::WS_W'(WINDOW_MAX);
		end else begin
			n_w = window_size_q;
		end
	end

	// pointer wraps when the window shrinks
	assign slot_w   = (CMP_W'(wp_q) >= CMP_W'(n_w)) ? '0 : wp_q;
	assign slot_inc = CMP_W'(slot_q) + 1'b1;
	assign accept   = in_valid && !in_stall;
	assign full_w   = (fill_q >= n_w);
	assign emit_go  = !out_valid_q || !out_stall;
	assign in_stall = (state_q != sma_pkg::ST_IDLE);

	sma_window #(
		.DEPTH  (WINDOW_MAX),
		.ADDR_W (PTR_W)
	) u_window (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (slot_w),
		.rd_data (old_sample),
		.wr_en   (state_q == sma_pkg::ST_UPDATE),
		.wr_addr (slot_q),
		.wr_data (sample_q)
	);

	// numerator 20*sum + n, divisor 2n
	always_comb begin
		div_req.start = (state_q == sma_pkg::ST_LOAD);
		div_req.num   = (sma_pkg::NUM_W'(sum_q) << 4) + (sma_pkg::NUM_W'(sum_q) << 2)
		              + sma_pkg::NUM_W'(n_w);
		div_req.den   = {n_w, 1'b0};
	end

	sma_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.stat     (div_stat),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sma_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sma_pkg::ST_IDLE: begin
				if (accept && n_w != '0) begin
					state_d = sma_pkg::ST_UPDATE;
				end
			end
			sma_pkg::ST_UPDATE: begin
				// full after this sample means a result follows
				if (full_w || (fill_q + 1'b1 >= n_w)) begin
					state_d = sma_pkg::ST_LOAD;
				end else begin
					state_d = sma_pkg::ST_IDLE;
				end
			end
			sma_pkg::ST_LOAD: begin
				state_d = sma_pkg::ST_DIVIDE;
			end
			sma_pkg::ST_DIVIDE: begin
				if (div_stat.done) begin
					state_d = sma_pkg::ST_EMIT;
				end
			end
			sma_pkg::ST_EMIT: begin
				if (emit_go) begin
					state_d = sma_pkg::ST_IDLE;
				end
			end
			default: state_d = sma_pkg::ST_IDLE;
		endcase
	end

	// history and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= sma_pkg::WINDOW_SIZE_RST;
			sum_q         <= '0;
			fill_q        <= '0;
			wp_q          <= '0;
		end else if (cfg_wr_en) begin
			window_size_q <= cfg_wr_data;
			sum_q         <= '0;
			fill_q        <= '0;
			wp_q          <= '0;
		end else begin
			unique case (state_q)
				sma_pkg::ST_IDLE: begin
					if (accept && n_w == '0 && end_of_list) begin
						sum_q  <= '0;
						fill_q <= '0;
						wp_q   <= '0;
					end
				end
				sma_pkg::ST_UPDATE: begin
					if (last_q && !(full_w || (fill_q + 1'b1 >= n_w))) begin
						sum_q  <= '0;
						fill_q <= '0;
						wp_q   <= '0;
					end else begin
						if (full_w) begin
							sum_q <= sum_q - sma_pkg::SUM_W'(old_sample)
							       + sma_pkg::SUM_W'(sample_q);
						end else begin
							sum_q  <= sum_q + sma_pkg::SUM_W'(sample_q);
							fill_q <= fill_q + 1'b1;
						end
						wp_q <= (slot_inc >= CMP_W'(n_w)) ? '0 : PTR_W'(slot_inc);
					end
				end
				sma_pkg::ST_EMIT: begin
					if (emit_go && last_q) begin
						sum_q  <= '0;
						fill_q <= '0;
						wp_q   <= '0;
					end
				end
				sma_pkg::ST_LOAD, sma_pkg::ST_DIVIDE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample_value;
			last_q   <= end_of_list;
			slot_q   <= slot_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == sma_pkg::ST_EMIT && emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sma_pkg::ST_EMIT && emit_go) begin
			avg_q <= quotient[sma_pkg::AVG_W-1:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign average_tenths = avg_q;

	`SMA_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= n_w)
	`SMA_ASSERT_NOW(a_emit_source, $rose(out_valid_q), $past(state_q) == sma_pkg::ST_EMIT)
	`SMA_ASSERT_NEXT(a_accept_update, accept && n_w != '0, state_q == sma_pkg::ST_UPDATE)
	`SMA_ASSERT_NOW(a_divide_busy, state_q == sma_pkg::ST_DIVIDE, div_stat.busy)

endmodule

`default_nettype wire

FILE: verif/tb_simple_moving_average.sv
`timescale 1ns / 1ps

module tb_simple_moving_average;

	localparam int IDLE_MAX      = 18;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 3000;
	localparam int RANDOM_ITEMS  = 1150;
	localparam int REPORT_MAX    = 10;
	localparam int WINDOW_CAP    = sma_pkg::WINDOW_MAX_DEF;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_wr_en;
	logic [sma_pkg::WS_W-1:0]     cfg_wr_data;
	logic                         in_valid;
	logic                         in_stall;
	logic [sma_pkg::SAMPLE_W-1:0] sample_value;
	logic                         end_of_list;
	logic                         out_valid;
	logic                         out_stall;
	logic [sma_pkg::AVG_W-1:0]    average_tenths;

	// shadow of the averaging state
	logic [sma_pkg::SAMPLE_W-1:0] win_mem [WINDOW_CAP];
	logic [sma_pkg::SUM_W-1:0]    win_sum;
	logic [sma_pkg::WS_W-1:0]     win_fill;
	logic [3:0]                   win_ptr;
	logic [sma_pkg::WS_W-1:0]     win_cfg;
	logic [sma_pkg::AVG_W-1:0]    avg_queue [$];

	logic [sma_pkg::AVG_W-1:0]    expected_avg;
	int                           mismatches;
	int                           quiet_cycles;
	int                           in_idle_max;
	int                           out_idle_max;

	simple_moving_average uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample_value   (sample_value),
		.end_of_list    (end_of_list),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.average_tenths (average_tenths)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int draw_idle(input int max_cycles);
		return (max_cycles == 0) ? 0 : int'($urandom_range(0, max_cycles));
	endfunction

	function automatic logic [sma_pkg::SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return sma_pkg::SAMPLE_W'($urandom_range(0, 15));
			default: return sma_pkg::SAMPLE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function void clear_window();
		win_sum  = '0;
		win_fill = '0;
		win_ptr  = '0;
	endfunction

	// window mean in tenths, half up: floor((20*sum + n) / 2n)
	function void predict_average(input logic [sma_pkg::SAMPLE_W-1:0] s, input logic eol);
		int unsigned n;
		int unsigned slot;
		int unsigned num;
		n = (32'(win_cfg) > WINDOW_CAP) ? WINDOW_CAP : 32'(win_cfg);
		if (n != 0) begin
			slot = 32'(win_ptr);
			if (slot >= n)
				slot = 0;
			if (win_fill >= n)
				win_sum = win_sum - sma_pkg::SUM_W'(win_mem[slot]);
			else
				win_fill = win_fill + 1'b1;
			win_mem[slot] = s;
			win_sum = win_sum + sma_pkg::SUM_W'(s);
			slot++;
			win_ptr = (slot >= n) ? '0 : 4'(slot);
			if (win_fill >= n) begin
				num = 32'(win_sum) * 20 + n;
				avg_queue.push_back(sma_pkg::AVG_W'(num / (2 * n)));
			end
		end
		if (eol)
			clear_window();
	endfunction

	task send_item(input logic [sma_pkg::SAMPLE_W-1:0] s, input logic eol);
		int gap;
		gap = draw_idle(in_idle_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		sample_value <= s;
		end_of_list  <= eol;
		predict_average(s, eol);
		do @(posedge clk); while (in_stall);
	endtask

	task drain_results;
		while (avg_queue.size() != 0) @(posedge clk);
		// items without a result may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task set_window(input logic [sma_pkg::WS_W-1:0] ws);
		in_valid <= 1'b0;
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ws;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		win_cfg = ws;
		clear_window();
	endtask

	// window of one straight after reset, full-scale extremes
	task test_window_one;
		in_idle_max  = 0;
		out_idle_max = 0;
		send_item('0, 1'b0);
		send_item('1, 1'b1);
	endtask

	// mean of 0.25 gives 2.5 tenths, which must round up
	task test_rounding_tie;
		set_window(5'd4);
		in_idle_max  = IDLE_MAX;
		out_idle_max = IDLE_MAX;
		send_item(16'd1, 1'b0);
		send_item(16'd0, 1'b0);
		send_item(16'd0, 1'b0);
		send_item(16'd0, 1'b1);
	endtask

	task test_short_list;
		send_item(16'd0, 1'b0);
		send_item(16'd5, 1'b1);
	endtask

	// oversized window acts as the maximum; full-scale sum
	task test_window_capped;
		set_window(5'd31);
		for (int k = 0; k < WINDOW_CAP; k++)
			send_item('1, k == WINDOW_CAP - 1);
	endtask

	task test_window_zero;
		set_window(5'd0);
		send_item(16'd123, 1'b1);
		send_item('1, 1'b0);
	endtask

	task test_random_lists;
		int sent;
		int n;
		int len;
		logic [sma_pkg::WS_W-1:0] ws;
		bit keep_open;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 11))
				0: ws = 5'd0;
				1: ws = sma_pkg::WS_W'($urandom_range(17, 31));
				2: ws = 5'd16;
				3: ws = 5'd1;
				default: ws = sma_pkg::WS_W'($urandom_range(1, 16));
			endcase
			set_window(ws);
			in_idle_max  = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(3, IDLE_MAX));
			out_idle_max = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(3, IDLE_MAX));
			n = (int'(ws) > WINDOW_CAP) ? WINDOW_CAP : int'(ws);
			repeat ($urandom_range(1, 4)) begin
				if (n == 0)
					len = int'($urandom_range(1, 4));
				else if ($urandom_range(0, 3) == 0)
					len = int'($urandom_range(1, n));
				else
					len = n + int'($urandom_range(0, 24));
				// an open list runs on into the next one, or is cut by the next window write
				keep_open = ($urandom_range(0, 4) == 0);
				for (int k = 0; k < len; k++)
					send_item(random_sample(),
						((k == len - 1) && !keep_open) || ($urandom_range(0, 49) == 0));
				if (n != 0)
					sent += len;
			end
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		in_valid     = 1'b0;
		sample_value = '0;
		end_of_list  = 1'b0;
		in_idle_max  = 0;
		out_idle_max = 0;
		mismatches   = 0;
		for (int i = 0; i < WINDOW_CAP; i++)
			win_mem[i] = '0;
		win_cfg = sma_pkg::WINDOW_SIZE_RST;
		clear_window();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_window_one();
		test_rounding_tie();
		test_short_list();
		test_window_capped();
		test_window_zero();
		test_random_lists();

		in_valid <= 1'b0;
		drain_results();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// receiver: random hold-off per item, then take the next result
	initial begin : receiver
		int hold;
		out_stall = 1'b0;
		forever begin
			hold = draw_idle(out_idle_max);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (avg_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected average item: got %0d", average_tenths);
			end else begin
				expected_avg = avg_queue.pop_front();
				if (average_tenths !== expected_avg) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("average_tenths mismatch: expected %0d, got %0d",
							expected_avg, average_tenths);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("Mismatches found");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial quiet_cycles = 0;

endmodule
